/* src/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on a rising edge and held off
// while the asynchronous reset is active.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error(msg);

// The condition must never be true at a clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error(msg);

`endif

/* src/fcpp_pkg.sv */
// ----------------------------------------------------------------------------
// fcpp_pkg
// Types and constants shared by the framed command packet parser modules.
// ----------------------------------------------------------------------------
package fcpp_pkg;

	localparam logic [7:0] START_BYTE    = 8'h16;
	localparam logic [7:0] END_BYTE      = 8'h19;
	localparam logic [7:0] CLASS_TIME    = 8'h40;
	localparam logic [7:0] CLASS_TOKEN   = 8'h80;
	localparam logic [7:0] MIN_LEN_TIME  = 8'd8;
	localparam logic [7:0] MIN_LEN_TOKEN = 8'd9;
	localparam logic [7:0] MIN_LEN_FRAME = 8'd3;

	localparam int OUT_DATA_W = 64;

	typedef enum logic [2:0] {
		ST_TIME_SET  = 3'd0,
		ST_TOKEN_SET = 3'd1,
		ST_UNKNOWN   = 3'd2,
		ST_CHECKSUM  = 3'd3,
		ST_FRAME_ERR = 3'd4
	} status_t;

	// One received byte with its buffer start flag.
	typedef struct packed {
		logic [7:0] data_byte;
		logic       buffer_start;
	} in_item_t;

	// One parse result.
	typedef struct packed {
		status_t     status;
		logic [7:0]  hour_value;
		logic [7:0]  minute_value;
		logic [7:0]  second_value;
		logic [31:0] token_value;
	} result_t;

	// Handshake between the parser and the result register.
	typedef struct packed {
		logic step;
		logic emit;
	} parse_ctl_t;

endpackage

/* src/fcpp_in_stage.sv */
// ----------------------------------------------------------------------------
// fcpp_in_stage
// Input register: holds one accepted byte until the parser consumes it.
// ----------------------------------------------------------------------------
module fcpp_in_stage (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [7:0]        s_tdata,
	input  logic              s_tuser,
	input  logic              advance,
	output logic              valid_s1,
	output fcpp_pkg::in_item_t item_s1
);

	logic load;

	assign s_tready = !valid_s1 || advance;
	assign load     = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_s1.data_byte    <= s_tdata;
			item_s1.buffer_start <= s_tuser;
		end
	end

endmodule

/* src/fcpp_parser.sv */
// ----------------------------------------------------------------------------
// fcpp_parser
// Packet state and the per-byte decision logic. Produces one result when the
// end byte or a too-short length byte arrives.
// ----------------------------------------------------------------------------
module fcpp_parser (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                valid_s1,
	input  fcpp_pkg::in_item_t  item_s1,
	input  logic                advance,
	output fcpp_pkg::parse_ctl_t ctl,
	output fcpp_pkg::result_t   result
);

	logic        in_packet_q;
	logic [7:0]  pos_q;
	logic [7:0]  len_q;
	logic [7:0]  kind_q;
	logic [7:0]  sum_q;
	logic        start_ok_q;
	logic        sum_ok_q;
	logic [31:0] payload_q;

	// State as seen by the current byte, after a possible restart.
	logic        restart;
	logic [7:0]  pos;
	logic [7:0]  len;
	logic [7:0]  kind;
	logic [7:0]  sum;
	logic        start_ok;
	logic        sum_ok;
	logic [31:0] payload;

	logic        in_packet_d;
	logic [7:0]  len_d;
	logic [7:0]  kind_d;
	logic        start_ok_d;
	logic        sum_ok_d;
	logic [31:0] payload_d;

	logic        active;
	logic        process;
	logic [7:0]  b;
	logic        emit;
	logic        is_end;
	fcpp_pkg::result_t res;

	assign b       = item_s1.data_byte;
	assign restart = item_s1.buffer_start;
	assign active  = restart || in_packet_q;
	assign process = valid_s1 && advance && active;

	assign pos      = restart ? 8'd0  : pos_q;
	assign len      = restart ? 8'd0  : len_q;
	assign kind     = restart ? 8'd0  : kind_q;
	assign sum      = restart ? 8'd0  : sum_q;
	assign start_ok = restart ? 1'b0  : start_ok_q;
	assign sum_ok   = restart ? 1'b0  : sum_ok_q;
	assign payload  = restart ? 32'd0 : payload_q;

	always_comb begin
		in_packet_d = 1'b1;
		len_d       = len;
		kind_d      = kind;
		start_ok_d  = start_ok;
		sum_ok_d    = sum_ok;
		payload_d   = payload;
		emit        = 1'b0;
		is_end      = 1'b0;
		res         = '{status: fcpp_pkg::ST_FRAME_ERR, default: '0};

		if (pos == 8'd0) begin
			start_ok_d = (b == fcpp_pkg::START_BYTE);
		end else if (pos == 8'd1) begin
			len_d = b;
			if (b < fcpp_pkg::MIN_LEN_FRAME) begin
				in_packet_d = 1'b0;
				emit        = 1'b1;
			end
		end else begin
			if (pos == 8'd2) begin
				kind_d = b;
			end
			if (pos >= 8'd3 && pos <= 8'd6) begin
				payload_d = {payload[23:0], b};
			end
			// Nine-bit compares: the position plus its offset must not wrap.
			if (({1'b0, pos} + 9'd2) == {1'b0, len}) begin
				sum_ok_d = (sum == b);
			end
			if (({1'b0, pos} + 9'd1) == {1'b0, len}) begin
				in_packet_d = 1'b0;
				emit        = 1'b1;
				is_end      = 1'b1;
			end
		end

		// The class byte can itself be the end byte, so the decision
		// looks at the updated class.
		if (is_end && start_ok && b == fcpp_pkg::END_BYTE) begin
			if (kind_d == fcpp_pkg::CLASS_TIME) begin
				if (len < fcpp_pkg::MIN_LEN_TIME) begin
					res.status = fcpp_pkg::ST_FRAME_ERR;
				end else if (!sum_ok) begin
					res.status = fcpp_pkg::ST_CHECKSUM;
				end else begin
					res.status       = fcpp_pkg::ST_TIME_SET;
					res.hour_value   = payload[31:24];
					res.minute_value = payload[23:16];
					res.second_value = payload[15:8];
				end
			end else if (kind_d == fcpp_pkg::CLASS_TOKEN) begin
				if (len < fcpp_pkg::MIN_LEN_TOKEN) begin
					res.status = fcpp_pkg::ST_FRAME_ERR;
				end else if (!sum_ok) begin
					res.status = fcpp_pkg::ST_CHECKSUM;
				end else begin
					res.status      = fcpp_pkg::ST_TOKEN_SET;
					res.token_value = payload;
				end
			end else begin
				res.status = fcpp_pkg::ST_UNKNOWN;
			end
		end
	end

	assign ctl.step = valid_s1 && advance;
	assign ctl.emit = process && emit;
	assign result   = res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_packet_q <= 1'b0;
			pos_q       <= '0;
			len_q       <= '0;
			kind_q      <= '0;
			sum_q       <= '0;
			start_ok_q  <= 1'b0;
			sum_ok_q    <= 1'b0;
			payload_q   <= '0;
		end else if (process) begin
			in_packet_q <= in_packet_d;
			pos_q       <= pos + 8'd1;
			len_q       <= len_d;
			kind_q      <= kind_d;
			sum_q       <= sum + b;
			start_ok_q  <= start_ok_d;
			sum_ok_q    <= sum_ok_d;
			payload_q   <= payload_d;
		end
	end

endmodule

/* src/fcpp_out_stage.sv */
// ----------------------------------------------------------------------------
// fcpp_out_stage
// Result register: holds one result item until the consumer takes it.
// ----------------------------------------------------------------------------
module fcpp_out_stage (
	input  logic                        clk,
	input  logic                        arst_n,
	input  fcpp_pkg::parse_ctl_t        ctl,
	input  fcpp_pkg::result_t           result,
	output logic                        can_load,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [fcpp_pkg::OUT_DATA_W-1:0] m_tdata
);

	logic [fcpp_pkg::OUT_DATA_W-1:0] data_q;

	assign can_load = !m_tvalid || m_tready;
	assign m_tdata  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (can_load) begin
			m_tvalid <= ctl.step && ctl.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (can_load && ctl.emit) begin
			data_q <= {5'd0, result.token_value, result.second_value,
				result.minute_value, result.hour_value, result.status};
		end
	end

endmodule

/* src/framed_command_packet_parser_unit.sv */
// ----------------------------------------------------------------------------
// framed_command_packet_parser_unit
// Parses a byte stream of start/length/end framed packets with an additive
// checksum and reports one status item per packet.
// ----------------------------------------------------------------------------
//  channel | dir | tdata (low bit first)                          | tuser
//  s_      | in  | data_byte[7:0]                                 | buffer_start
//  m_      | out | status[2:0] hour minute second token[31:0] 0s  | -
//
// One input item is taken every cycle while the result side is not stalled; the end
// byte passes the input register, then the result register, before m_tvalid rises.
// The packet state registers are updated once per byte in a single pass.
// Reset clears the packet state and both valid flags; no clearing pass.
// A stalled result holds the parser; the input register then fills and holds the input side.
module framed_command_packet_parser_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // data_byte[7:0]
	input  logic        s_tuser,   // buffer_start
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata    // status[2:0], hour[10:3], minute[18:11],
	                               // second[26:19], token[58:27], zeros above
);

	logic                 valid_s1;
	fcpp_pkg::in_item_t   item_s1;
	logic                 advance;
	fcpp_pkg::parse_ctl_t ctl;
	fcpp_pkg::result_t    result;

	fcpp_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	fcpp_parser u_parser (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1),
		.advance  (advance),
		.ctl      (ctl),
		.result   (result)
	);

	fcpp_out_stage u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.result   (result),
		.can_load (advance),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

/* src/fcpp_port_monitor.sv */
// ----------------------------------------------------------------------------
// fcpp_port_monitor
// Port-level checks on the result stream of the packet parser.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fcpp_port_monitor (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [63:0] m_tdata
);

	`ASSERT_PROP(a_valid_holds, clk, arst_n, m_tvalid && !m_tready |=> m_tvalid, "result dropped while stalled")
	`ASSERT_PROP(a_data_holds, clk, arst_n, m_tvalid && !m_tready |=> $stable(m_tdata), "result changed while stalled")
	`ASSERT_NEVER(a_status_range, clk, arst_n, m_tvalid && (m_tdata[2:0] > 3'd4 || m_tdata[63:59] != 5'd0), "status code or padding out of range")
	`ASSERT_NEVER(a_time_fields, clk, arst_n, m_tvalid && m_tdata[2:0] != 3'd0 && m_tdata[26:3] != 24'd0, "time fields set without time status")
	`ASSERT_NEVER(a_token_field, clk, arst_n, m_tvalid && m_tdata[2:0] != 3'd1 && m_tdata[58:27] != 32'd0, "token set without token status")

endmodule

bind framed_command_packet_parser_unit fcpp_port_monitor u_port_monitor (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
